// ===== rtl/fcrc_pkg.sv =====
// Package for the CRC-16 frame append/check unit.
// Holds the result word type, status and register codes and the byte-wide CRC update.
// No dependencies.
`timescale 1ns / 1ps

package fcrc_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic ModeGen   = 1'b0;
  localparam logic ModeCheck = 1'b1;

  localparam logic CfgMode  = 1'b0;
  localparam logic CfgStart = 1'b1;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadStart = 2'd1;
  localparam logic [1:0] StBadCrc   = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic [1:0] status;
  } res_t;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/fcrc_chan_if.sv =====
// Valid/ready channel interfaces for the CRC-16 frame append/check unit.
// One interface for the raw input bytes, one for the result words. No dependencies.
`timescale 1ns / 1ps

interface fcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface fcrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic [1:0] status;

  modport source (output valid, output out_byte, output frame_end, output status,
                  input ready);
  modport sink (input valid, input out_byte, input frame_end, input status,
                output ready);
endinterface

// ===== rtl/frame_crc16_append_check_unit.sv =====
// Byte-serial CRC-16 (reflected, poly 0xA001, init 0xFFFF) framer and checker.
// Depends on fcrc_pkg and the channel interfaces in fcrc_chan_if.sv.
`timescale 1ns / 1ps

// The unit takes one byte per clock and writes each result word into a
// two-entry output queue, so a word is offered on the output right after the
// edge that takes its byte. While the output is stalled the input takes one
// more byte and then waits until the queue has room again. Frames are
// FRAME_BYTES long. In generate mode (mode = 0) the unit takes
// FRAME_BYTES-2 payload bytes, forwards them, and appends the CRC high byte
// then low byte; the two appended words come from a pending register, one per
// cycle while the queue has room, and the input is held off until both are
// queued. In check mode (mode = 1) every byte is forwarded at one per cycle;
// the last word carries frame_end and a status of ok, bad start byte, or bad
// CRC, where a bad start byte wins. Writing the mode register aborts any
// partial frame. Configuration should be written only while idle.
module frame_crc16_append_check_unit
  import fcrc_pkg::*;
#(
  parameter int FRAME_BYTES = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  fcrc_in_if.sink         in_if,
  fcrc_out_if.source      out_if,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [7:0]      cfg_data
);

  localparam int PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] LastPayPos = PosW'(FRAME_BYTES - 3);
  localparam logic [PosW-1:0] CrcHiPos   = PosW'(FRAME_BYTES - 2);

  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendLow  = 2'd1;
  localparam logic [1:0] PendHigh = 2'd2;

  logic            mode_r, mode_nxt;
  logic [7:0]      start_byte_r, start_byte_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [7:0]      held_high_r, held_high_nxt;
  logic            start_good_r, start_good_nxt;
  logic [1:0]      pend_r, pend_nxt;
  logic [15:0]     pend_crc_r, pend_crc_nxt;

  res_t            fifo_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r, cnt_nxt;

  logic            room;
  logic            in_fire;
  logic            pop;
  logic            push;
  res_t            push_res;
  logic [15:0]     crc_upd;
  logic            sg;
  logic [15:0]     rx_crc;

  assign room         = (cnt_r != 2'd2);
  assign in_if.ready  = room && (pend_r == PendNone);
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = (cnt_r != 2'd0);
  assign pop          = out_if.valid && out_if.ready;

  assign out_if.out_byte  = fifo_r[rd_ptr_r].out_byte;
  assign out_if.frame_end = fifo_r[rd_ptr_r].frame_end;
  assign out_if.status    = fifo_r[rd_ptr_r].status;

  assign crc_upd = crc16_byte(crc_r, in_if.data_byte);
  assign sg      = (pos_r == '0) ? (in_if.data_byte == start_byte_r) : start_good_r;
  assign rx_crc  = {held_high_r, in_if.data_byte};

  always_comb begin
    mode_nxt       = mode_r;
    start_byte_nxt = start_byte_r;
    crc_nxt        = crc_r;
    pos_nxt        = pos_r;
    held_high_nxt  = held_high_r;
    start_good_nxt = start_good_r;
    pend_nxt       = pend_r;
    pend_crc_nxt   = pend_crc_r;
    push           = 1'b0;
    push_res       = '{out_byte: in_if.data_byte, frame_end: 1'b0, status: StOk};

    if (in_fire) begin
      push = 1'b1;
      if (mode_r == ModeGen) begin
        if (pos_r >= LastPayPos) begin
          // Last payload byte: queue it, then the two CRC bytes follow.
          pend_nxt       = PendHigh;
          pend_crc_nxt   = crc_upd;
          crc_nxt        = CrcInit;
          pos_nxt        = '0;
          start_good_nxt = 1'b1;
        end else begin
          crc_nxt = crc_upd;
          pos_nxt = pos_r + PosW'(1);
        end
      end else begin
        if (pos_r < CrcHiPos) begin
          crc_nxt        = crc_upd;
          start_good_nxt = sg;
          pos_nxt        = pos_r + PosW'(1);
        end else if (pos_r == CrcHiPos) begin
          held_high_nxt  = in_if.data_byte;
          start_good_nxt = sg;
          pos_nxt        = pos_r + PosW'(1);
        end else begin
          push_res.frame_end = 1'b1;
          if (!sg) begin
            push_res.status = StBadStart;
          end else if (rx_crc != crc_r) begin
            push_res.status = StBadCrc;
          end else begin
            push_res.status = StOk;
          end
          crc_nxt        = CrcInit;
          pos_nxt        = '0;
          start_good_nxt = 1'b1;
        end
      end
    end else if ((pend_r != PendNone) && room) begin
      push = 1'b1;
      if (pend_r == PendHigh) begin
        push_res = '{out_byte: pend_crc_r[15:8], frame_end: 1'b0, status: StOk};
        pend_nxt = PendLow;
      end else begin
        push_res = '{out_byte: pend_crc_r[7:0], frame_end: 1'b1, status: StOk};
        pend_nxt = PendNone;
      end
    end

    if (cfg_we) begin
      unique case (cfg_idx)
        CfgMode: begin
          mode_nxt       = cfg_data[0];
          crc_nxt        = CrcInit;
          pos_nxt        = '0;
          start_good_nxt = 1'b1;
          pend_nxt       = PendNone;
        end
        CfgStart: begin
          start_byte_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= ModeCheck;
      start_byte_r <= 8'h00;
      crc_r        <= CrcInit;
      pos_r        <= '0;
      start_good_r <= 1'b1;
      pend_r       <= PendNone;
      cnt_r        <= 2'd0;
      wr_ptr_r     <= 1'b0;
      rd_ptr_r     <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      start_byte_r <= start_byte_nxt;
      crc_r        <= crc_nxt;
      pos_r        <= pos_nxt;
      start_good_r <= start_good_nxt;
      pend_r       <= pend_nxt;
      cnt_r        <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_high_r <= held_high_nxt;
    pend_crc_r  <= pend_crc_nxt;
    if (push) begin
      fifo_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

// ===== tb/frame_crc16_append_check_unit_tb.sv =====
// Testbench for frame_crc16_append_check_unit: drives byte frames in generate and check
// modes and checks every result word against a cycle-free CRC-16 frame predictor.
// Depends on fcrc_pkg and the channel interfaces in fcrc_chan_if.sv.
`timescale 1ns / 1ps

module frame_crc16_append_check_unit_tb
  import fcrc_pkg::*;
();

  localparam int FRAME_BYTES  = 64;
  localparam int SettleCycles = 4;
  localparam int NumFrames    = 4;
  localparam int CalmFrames   = 1;
  localparam int CycleLimit   = 400000;

  typedef enum {
    FrGen, FrCheckGood, FrBadStart, FrBadBoth, FrBadCrc, FrPartial, FrNoise
  } frame_kind_t;

  // Tracks the frame state of the unit and holds the words it has to produce.
  class crc_frame_scoreboard;
    logic        mode_q;
    logic [7:0]  start_q;
    logic [15:0] crc_q;
    logic [7:0]  pos_q;
    logic [7:0]  hi_q;
    logic        start_ok_q;
    res_t        expected_words[$];
    int unsigned errors;
    int unsigned words_checked;
    int unsigned end_count[4];

    function new();
      mode_q = ModeCheck;
      start_q = 8'h00;
      hi_q = 8'h00;
      errors = 0;
      words_checked = 0;
      foreach (end_count[i]) end_count[i] = 0;
      restart();
    endfunction

    function void restart();
      crc_q = CrcInit;
      pos_q = 8'd0;
      start_ok_q = 1'b1;
    endfunction

    static function logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c = c >> 1;
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void write_reg(logic idx, logic [7:0] data);
      if (idx == CfgMode) begin
        mode_q = data[0];
        restart();
      end else begin
        start_q = data;
      end
    endfunction

    function void queue_word(logic [7:0] b, logic last, logic [1:0] st);
      res_t w;
      w.out_byte = b;
      w.frame_end = last;
      w.status = st;
      expected_words.push_back(w);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [1:0] st;
      if (mode_q == ModeGen) begin
        crc_q = crc_next(crc_q, b);
        queue_word(b, 1'b0, StOk);
        if (pos_q >= FRAME_BYTES - 3) begin
          queue_word(crc_q[15:8], 1'b0, StOk);
          queue_word(crc_q[7:0], 1'b1, StOk);
          restart();
        end else begin
          pos_q++;
        end
        return;
      end
      if (pos_q == 0) start_ok_q = (b == start_q);
      if (pos_q < FRAME_BYTES - 2) begin
        crc_q = crc_next(crc_q, b);
        queue_word(b, 1'b0, StOk);
        pos_q++;
      end else if (pos_q == FRAME_BYTES - 2) begin
        hi_q = b;
        queue_word(b, 1'b0, StOk);
        pos_q++;
      end else begin
        // A wrong first byte outranks a wrong CRC.
        if (!start_ok_q) st = StBadStart;
        else if ({hi_q, b} != crc_q) st = StBadCrc;
        else st = StOk;
        queue_word(b, 1'b1, st);
        restart();
      end
    endfunction

    function void check_word(logic [7:0] b, logic last, logic [1:0] st);
      res_t exp_w;
      words_checked++;
      if (last) end_count[st]++;
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_byte=%02h frame_end=%0b status=%0d", b, last, st);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (b !== exp_w.out_byte) begin
        $error("out_byte mismatch: expected %02h, got %02h", exp_w.out_byte, b);
        errors++;
      end
      if (last !== exp_w.frame_end) begin
        $error("frame_end mismatch: expected %0b, got %0b", exp_w.frame_end, last);
        errors++;
      end
      if (st !== exp_w.status) begin
        $error("status mismatch: expected %0d, got %0d", exp_w.status, st);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_data;
  bit         bursts_on;
  int unsigned cycle_count;

  fcrc_in_if  in_ch ();
  fcrc_out_if out_ch ();

  crc_frame_scoreboard sb;

  frame_crc16_append_check_unit #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: with bursts_on, ready alternates random stalls and open stretches.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (bursts_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.out_byte, out_ch.frame_end, out_ch.status);
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]  frame_bytes[$];
    logic [15:0] crc;
    logic [7:0]  first;
    logic [7:0]  cfg_val;
    logic        want_mode;
    int unsigned len;
    case (kind)
      FrGen: want_mode = ModeGen;
      FrPartial, FrNoise: want_mode = 1'($urandom_range(0, 1));
      default: want_mode = ModeCheck;
    endcase
    if (sb.mode_q != want_mode) begin
      wait_drained();
      cfg_val = 8'($urandom_range(0, 255));
      cfg_val[0] = want_mode;
      write_cfg(CfgMode, cfg_val);
    end

    if (kind == FrPartial || kind == FrNoise || kind == FrGen) begin
      if (kind == FrPartial)
        len = (want_mode == ModeGen) ? $urandom_range(1, FRAME_BYTES - 3)
                                     : $urandom_range(1, FRAME_BYTES - 1);
      else
        len = (want_mode == ModeGen) ? FRAME_BYTES - 2 : FRAME_BYTES;
      repeat (len) frame_bytes.push_back(rand_byte());
    end else begin
      // Well-formed check frame, optionally with a wrong start byte or trailer.
      if (kind == FrBadStart || kind == FrBadBoth)
        first = sb.start_q ^ 8'($urandom_range(1, 255));
      else
        first = sb.start_q;
      frame_bytes.push_back(first);
      crc = crc_frame_scoreboard::crc_next(CrcInit, first);
      repeat (FRAME_BYTES - 3) begin
        frame_bytes.push_back(rand_byte());
        crc = crc_frame_scoreboard::crc_next(crc, frame_bytes[$]);
      end
      if (kind == FrBadCrc || kind == FrBadBoth) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      frame_bytes.push_back(crc[15:8]);
      frame_bytes.push_back(crc[7:0]);
    end

    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);

    // Rewriting the mode, even unchanged, drops the partial frame.
    if (kind == FrPartial) begin
      wait_drained();
      cfg_val = 8'($urandom_range(0, 255));
      cfg_val[0] = want_mode;
      write_cfg(CfgMode, cfg_val);
    end
  endtask

  function automatic frame_kind_t pick_kind(int unsigned n);
    int unsigned r;
    case (n)
      0: return FrGen;
      1: return FrCheckGood;
      2: return FrBadBoth;
      3: return FrBadCrc;
      default: ;
    endcase
    r = $urandom_range(0, 99);
    if (r < 25) return FrGen;
    if (r < 55) return FrCheckGood;
    if (r < 65) return FrBadStart;
    if (r < 75) return FrBadBoth;
    if (r < 85) return FrBadCrc;
    if (r < 95) return FrPartial;
    return FrNoise;
  endfunction

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgMode;
    cfg_data = 8'h00;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    bursts_on = 1'b1;
    cycle_count = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Straight out of reset the unit is in check mode with a start byte of zero.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    wait_drained();
    write_cfg(CfgMode, 8'hFE);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h7F);
    wait_drained();
    write_cfg(CfgMode, 8'h00);
    send_byte(8'hA5);
    send_byte(8'h5A);
    wait_drained();
    write_cfg(CfgStart, 8'hFF);
    write_cfg(CfgMode, 8'h03);
    send_byte(8'hFF);
    send_byte(8'hFE);
    send_byte(8'h01);
    wait_drained();
    write_cfg(CfgMode, 8'h01);
    write_cfg(CfgStart, 8'h00);

    for (int n = 0; n < NumFrames; n++) begin
      bursts_on = (n < NumFrames - CalmFrames) && ($urandom_range(0, 3) != 0);
      if (n > 1 && $urandom_range(0, 1) == 0) begin
        wait_drained();
        case ($urandom_range(0, 2))
          0: write_cfg(CfgStart, 8'h00);
          1: write_cfg(CfgStart, 8'hFF);
          default: write_cfg(CfgStart, 8'($urandom_range(0, 255)));
        endcase
      end
      send_frame(pick_kind(n));
    end

    wait_drained();
    repeat (2 * SettleCycles) @(negedge clk);
    $display("Checked %0d words in both modes, with partial frames cut short by mode writes.",
             sb.words_checked);
    $display("Frame ends seen: %0d ok, %0d bad start byte, %0d bad CRC.",
             sb.end_count[StOk], sb.end_count[StBadStart], sb.end_count[StBadCrc]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
